/* rtl/modexp_pkg.sv */
package modexp_pkg;

    localparam int OPERAND_BITS  = 32;
    localparam int EXPONENT_BITS = 63;
    localparam int CNT_BITS      = $clog2(OPERAND_BITS);
    localparam int PC_BITS       = 4;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(OPERAND_BITS - 1);

    typedef logic [OPERAND_BITS-1:0]  operand_t;
    typedef logic [OPERAND_BITS:0]    wide_t;
    typedef logic [EXPONENT_BITS-1:0] exponent_t;
    typedef logic [PC_BITS-1:0]       pc_t;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SET_ONE,
        OP_SET_ZERO,
        OP_INIT,
        OP_REM,
        OP_BASE_STORE,
        OP_CLEAR,
        OP_MUL_ACC,
        OP_ACC_STORE,
        OP_MUL_SQ,
        OP_SQ_STORE,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_EXP_ZERO,
        C_MOD_ZERO,
        C_BIT0_CLR,
        C_CNT_NZ,
        C_EXP_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic exp_zero;
        logic mod_zero;
        logic exp_bit0;
        logic exp_more;
        logic cnt_nz;
        logic out_busy;
    } status_t;

    localparam pc_t STEP_IDLE     = 4'd0;
    localparam pc_t STEP_CHK_EXP  = 4'd1;
    localparam pc_t STEP_CHK_MOD  = 4'd2;
    localparam pc_t STEP_INIT     = 4'd3;
    localparam pc_t STEP_REM      = 4'd4;
    localparam pc_t STEP_BASE     = 4'd5;
    localparam pc_t STEP_BIT      = 4'd6;
    localparam pc_t STEP_MUL_ACC  = 4'd7;
    localparam pc_t STEP_ACC_ST   = 4'd8;
    localparam pc_t STEP_SQ_CLR   = 4'd9;
    localparam pc_t STEP_MUL_SQ   = 4'd10;
    localparam pc_t STEP_SQ_ST    = 4'd11;
    localparam pc_t STEP_EMIT     = 4'd12;
    localparam pc_t STEP_RETURN   = 4'd13;

    // Microprogram: right-to-left square and multiply
    function automatic ctrl_word_t ucode(input pc_t pc);
        ctrl_word_t w;
        begin
            case (pc)
                STEP_IDLE:    w = '{op: OP_LOAD,       cond: C_NO_INPUT, target: STEP_IDLE};
                STEP_CHK_EXP: w = '{op: OP_SET_ONE,    cond: C_EXP_ZERO, target: STEP_EMIT};
                STEP_CHK_MOD: w = '{op: OP_SET_ZERO,   cond: C_MOD_ZERO, target: STEP_EMIT};
                STEP_INIT:    w = '{op: OP_INIT,       cond: C_NEVER,    target: STEP_IDLE};
                STEP_REM:     w = '{op: OP_REM,        cond: C_CNT_NZ,   target: STEP_REM};
                STEP_BASE:    w = '{op: OP_BASE_STORE, cond: C_NEVER,    target: STEP_IDLE};
                STEP_BIT:     w = '{op: OP_CLEAR,      cond: C_BIT0_CLR, target: STEP_SQ_CLR};
                STEP_MUL_ACC: w = '{op: OP_MUL_ACC,    cond: C_CNT_NZ,   target: STEP_MUL_ACC};
                STEP_ACC_ST:  w = '{op: OP_ACC_STORE,  cond: C_NEVER,    target: STEP_IDLE};
                STEP_SQ_CLR:  w = '{op: OP_CLEAR,      cond: C_NEVER,    target: STEP_IDLE};
                STEP_MUL_SQ:  w = '{op: OP_MUL_SQ,     cond: C_CNT_NZ,   target: STEP_MUL_SQ};
                STEP_SQ_ST:   w = '{op: OP_SQ_STORE,   cond: C_EXP_MORE, target: STEP_BIT};
                STEP_EMIT:    w = '{op: OP_EMIT,       cond: C_OUT_BUSY, target: STEP_EMIT};
                STEP_RETURN:  w = '{op: OP_NOP,        cond: C_ALWAYS,   target: STEP_IDLE};
                default:      w = '{op: OP_NOP,        cond: C_ALWAYS,   target: STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

/* rtl/modexp_if.sv */
interface modexp_in_if;
    import modexp_pkg::*;

    logic      valid;
    logic      ready;
    operand_t  base_value;
    exponent_t exponent;
    operand_t  modulus;

    modport source (output valid, output base_value, output exponent, output modulus,
                    input ready);
    modport sink   (input valid, input base_value, input exponent, input modulus,
                    output ready);
endinterface

interface modexp_out_if;
    import modexp_pkg::*;

    logic     valid;
    logic     ready;
    operand_t power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

/* rtl/modexp_seq.sv */
module modexp_seq
    import modexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  status_t    status,
    output ctrl_word_t ctrl
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic taken;

    assign ctrl = ucode(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_INPUT: taken = !status.in_valid;
            C_EXP_ZERO: taken = status.exp_zero;
            C_MOD_ZERO: taken = status.mod_zero;
            C_BIT0_CLR: taken = !status.exp_bit0;
            C_CNT_NZ:   taken = status.cnt_nz;
            C_EXP_MORE: taken = status.exp_more;
            C_OUT_BUSY: taken = status.out_busy;
            default:    taken = 1'b1;
        endcase
        pc_next = taken ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // A counted loop step always falls through once the counter runs out
    a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cond == C_CNT_NZ && !status.cnt_nz) |=> (pc_reg == $past(pc_reg) + 1'b1))
        else $error("counted loop did not exit");

endmodule

/* rtl/modular_exponentiation_core.sv */
// Channel | Dir | Fields                               | Handshake
// req     | in  | base_value[32] exponent[63] modulus[32] | valid/ready
// rsp     | out | power_result[32]                     | valid/ready
//
// One item at a time, run by a 14-step microprogram: a new request is
// taken only once the result of the last one is in the output register.
// Each modular product is one pass of the shift-add unit per multiplier bit.
// Reset clears the step counter and the output valid; nothing else.
// A stalled result holds in the output register while the next item is taken.
module modular_exponentiation_core
    import modexp_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    modexp_in_if.sink    req,
    modexp_out_if.source rsp
);

    ctrl_word_t ctrl;
    status_t    status;

    operand_t        acc_reg;
    operand_t        acc_next;
    operand_t        sq_reg;
    operand_t        sq_next;
    operand_t        prod_reg;
    operand_t        prod_next;
    operand_t        mod_reg;
    operand_t        mod_next;
    exponent_t       exp_reg;
    exponent_t       exp_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    operand_t        out_data_reg;
    operand_t        out_data_next;

    logic     out_free;
    wide_t    rem_shift;
    operand_t rem_step;
    wide_t    dbl;
    operand_t dbl_mod;
    operand_t mul_x;
    operand_t mul_y;
    wide_t    sum;
    operand_t mul_step;

    modexp_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (ctrl.op == OP_LOAD);
    assign rsp.valid = out_valid_reg;
    assign rsp.power_result = out_data_reg;

    assign status.in_valid = req.valid;
    assign status.exp_zero = (exp_reg == '0);
    assign status.mod_zero = (mod_reg == '0);
    assign status.exp_bit0 = exp_reg[0];
    assign status.exp_more = |exp_reg[EXPONENT_BITS-1:1];
    assign status.cnt_nz   = (cnt_reg != '0);
    assign status.out_busy = !out_free;

    // Shift-subtract remainder, one base bit per step
    always_comb
    begin
        rem_shift = {prod_reg, sq_reg[cnt_reg]};
        if (rem_shift >= {1'b0, mod_reg})
        begin
            rem_shift = rem_shift - {1'b0, mod_reg};
        end
        rem_step = rem_shift[OPERAND_BITS-1:0];
    end

    // Shift-add modular multiply, one multiplier bit per step, MSB first
    always_comb
    begin
        mul_x = (ctrl.op == OP_MUL_ACC) ? acc_reg : sq_reg;
        mul_y = sq_reg;
        dbl   = {prod_reg, 1'b0};
        if (dbl >= {1'b0, mod_reg})
        begin
            dbl = dbl - {1'b0, mod_reg};
        end
        dbl_mod = dbl[OPERAND_BITS-1:0];
        sum = {1'b0, dbl_mod};
        if (mul_y[cnt_reg])
        begin
            sum = sum + {1'b0, mul_x};
            if (sum >= {1'b0, mod_reg})
            begin
                sum = sum - {1'b0, mod_reg};
            end
        end
        mul_step = sum[OPERAND_BITS-1:0];
    end

    always_comb
    begin
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        prod_next      = prod_reg;
        mod_next       = mod_reg;
        exp_next       = exp_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (ctrl.op)
            OP_LOAD:
            begin
                if (req.valid)
                begin
                    sq_next  = req.base_value;
                    exp_next = req.exponent;
                    mod_next = req.modulus;
                end
            end
            OP_SET_ONE:  acc_next = operand_t'(1);
            OP_SET_ZERO: acc_next = '0;
            OP_INIT:
            begin
                acc_next  = (mod_reg == operand_t'(1)) ? '0 : operand_t'(1);
                prod_next = '0;
                cnt_next  = CNT_MAX;
            end
            OP_REM:
            begin
                prod_next = rem_step;
                cnt_next  = cnt_reg - 1'b1;
            end
            OP_BASE_STORE: sq_next = prod_reg;
            OP_CLEAR:
            begin
                prod_next = '0;
                cnt_next  = CNT_MAX;
            end
            OP_MUL_ACC, OP_MUL_SQ:
            begin
                prod_next = mul_step;
                cnt_next  = cnt_reg - 1'b1;
            end
            OP_ACC_STORE: acc_next = prod_reg;
            OP_SQ_STORE:
            begin
                sq_next  = prod_reg;
                exp_next = exp_reg >> 1;
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                end
            end
            OP_NOP: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        prod_reg     <= prod_next;
        mod_reg      <= mod_next;
        exp_reg      <= exp_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    // Operands of the multiplier stay reduced
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_MUL_ACC || ctrl.op == OP_MUL_SQ)
            |-> (prod_reg < mod_reg && acc_reg < mod_reg && sq_reg < mod_reg))
        else $error("multiplier operand not reduced");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (ctrl.op == OP_SET_ONE))
        else $error("accepted item did not reach the exponent check");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_EMIT && out_free) |=> (rsp.valid && rsp.power_result == $past(acc_reg)))
        else $error("result not placed in the output register");

endmodule
